FILE: sv/bitmap_page_allocator_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap page allocator
// Shorthand for clocked implication checks, reported through $error.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define BPA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bitmap page allocator: implication check failed");

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define BPA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bitmap page allocator: next-cycle check failed");

`endif

FILE: sv/bpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Shared constants, field widths and register and request codes.
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int PAGES_PER_ZONE_DEF = 1024;
   localparam int ZONE_COUNT         = 4;
   localparam int ZONE_W             = 2;
   localparam int PAGE_SHIFT         = 21;
   localparam int ADDR_W             = 48;
   localparam int FRAME_W            = 27;
   localparam int COUNT_W            = 11;
   localparam int CSR_INDEX_W        = 3;
   localparam int CSR_DATA_W         = 27;
   localparam int WORD_BITS          = 64;
   localparam int WORD_SEL_W         = 6;

   // Request kind carried in req_tuser
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // Low bit of the register index picks base frame or page count
   localparam logic CSR_SEL_BASE  = 1'b0;
   localparam logic CSR_SEL_PAGES = 1'b1;

endpackage

FILE: sv/bitmap_page_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page allocator, top level
// First-fit allocator of 2 MiB pages over four zones with a used-bit bitmap.
// ----------------------------------------------------------------------------
// One request is handled at a time; req_tready is high only while the block
// is idle. An allocate sets up each zone in turn, skipping empty ones, scans
// the 64-bit bitmap words that hold the zone, and then posts the result. A
// free compares the frame with the zones in order (up to four), reads and
// rewrites the matching bitmap word and posts the result. The single bitmap
// memory port, read one word per cycle, sets the allocate time. After reset
// the bitmap is swept to zero, one word per cycle; requests are held off
// meanwhile, configuration writes are taken as ever. The result sits in an
// output register, so the next request may start while a result still waits
// to be taken.
`include "bitmap_page_allocator_top_defines.svh"

module bitmap_page_allocator_top #(
   parameter int PAGES_PER_ZONE = bpa_pkg::PAGES_PER_ZONE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bpa_pkg::ADDR_W-1:0]      req_tdata,   // [47:0] address
   input  logic                            req_tuser,   // [0] kind
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bpa_pkg::ADDR_W-1:0]      rsp_tdata,   // [47:0] page_address
   output logic                            rsp_tuser,   // [0] success
   // configuration write port
   input  logic                            csr_we,
   input  logic [bpa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bpa_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // Bitmap geometry
   localparam int MAP_BITS  = bpa_pkg::ZONE_COUNT * PAGES_PER_ZONE;
   localparam int MAP_WORDS = (MAP_BITS + bpa_pkg::WORD_BITS - 1) / bpa_pkg::WORD_BITS;
   localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BIT_W     = $clog2(MAP_BITS + bpa_pkg::WORD_BITS + 1);
   localparam int CMP_W     = (BIT_W > bpa_pkg::COUNT_W) ? BIT_W : bpa_pkg::COUNT_W;
   localparam int FW        = bpa_pkg::FRAME_W;
   localparam int SW        = bpa_pkg::WORD_SEL_W;

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_AZONE  = 7'b0000100,
      ST_AEVAL  = 7'b0001000,
      ST_FZONE  = 7'b0010000,
      ST_FWRITE = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   // Zone registers
   logic [FW-1:0]                   base_ff  [bpa_pkg::ZONE_COUNT];
   logic [bpa_pkg::COUNT_W-1:0]     pages_ff [bpa_pkg::ZONE_COUNT];

   // Bitmap memory and its registered read port
   logic [bpa_pkg::WORD_BITS-1:0]   map_ff [MAP_WORDS];
   logic [bpa_pkg::WORD_BITS-1:0]   rdata_ff;
   logic [WORD_AW-1:0]              rd_addr;
   logic                            mem_we;
   logic [WORD_AW-1:0]              mem_wa;
   logic [bpa_pkg::WORD_BITS-1:0]   mem_wd;

   // Sequencer state
   state_type                       state_ff, state_in;
   logic [bpa_pkg::ZONE_W-1:0]      zone_ff, zone_in;
   logic [WORD_AW-1:0]              clr_ff, clr_in;
   logic [BIT_W-1:0]                wbase_ff, wbase_in;
   logic [BIT_W-1:0]                start_ff, start_in;
   logic [BIT_W-1:0]                end_ff, end_in;
   logic [BIT_W-1:0]                bitidx_ff, bitidx_in;
   logic [FW-1:0]                   frame_ff, frame_in;
   logic [FW-1:0]                   res_frame_ff, res_frame_in;
   logic                            res_ok_ff, res_ok_in;

   // Output register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bpa_pkg::ADDR_W-1:0]      rsp_data_ff, rsp_data_in;
   logic                            rsp_ok_ff, rsp_ok_in;

   // Scan datapath
   logic [CMP_W-1:0]                count_ext;
   logic [BIT_W-1:0]                zone_pages;
   logic [BIT_W-1:0]                zone_start;
   logic [BIT_W-1:0]                rem;
   logic [BIT_W-1:0]                lo_diff;
   logic [SW-1:0]                   lo_off;
   logic [bpa_pkg::WORD_BITS-1:0]   lo_mask;
   logic [bpa_pkg::WORD_BITS-1:0]   hi_mask;
   logic [bpa_pkg::WORD_BITS-1:0]   free_bits;
   logic [bpa_pkg::WORD_BITS-1:0]   low_bit;
   logic [SW-1:0]                   low_idx;
   logic [BIT_W-1:0]                page_off;
   logic [BIT_W-1:0]                next_wbase;
   logic [FW-1:0]                   frame_diff;
   logic                            zone_hit;
   logic                            on_top_zone;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ok_ff;

   // Zone page count, saturated to the zone size, and first bit of the zone
   always_comb begin
      count_ext  = CMP_W'(pages_ff[zone_ff]);
      zone_pages = (count_ext > CMP_W'(PAGES_PER_ZONE)) ? BIT_W'(PAGES_PER_ZONE)
                                                       : BIT_W'(count_ext);
      unique case (zone_ff)
         2'd0:    zone_start = '0;
         2'd1:    zone_start = BIT_W'(PAGES_PER_ZONE);
         2'd2:    zone_start = BIT_W'(2 * PAGES_PER_ZONE);
         default: zone_start = BIT_W'(3 * PAGES_PER_ZONE);
      endcase
      on_top_zone = (zone_ff == bpa_pkg::ZONE_W'(bpa_pkg::ZONE_COUNT - 1));
   end

   // Free-bit search in the current word, clipped to the zone's bit range
   always_comb begin
      rem        = end_ff - wbase_ff;
      lo_diff    = start_ff - wbase_ff;
      lo_off     = (start_ff > wbase_ff) ? lo_diff[SW-1:0] : '0;
      lo_mask    = ~((64'd1 << lo_off) - 64'd1);
      hi_mask    = (rem >= BIT_W'(bpa_pkg::WORD_BITS)) ? '1
                                                        : ((64'd1 << rem[SW-1:0]) - 64'd1);
      free_bits  = ~rdata_ff & lo_mask & hi_mask;
      low_bit    = free_bits & (~free_bits + 64'd1);
      low_idx    = '0;
      for (int b = 0; b < bpa_pkg::WORD_BITS; b++) begin
         if (low_bit[b]) begin
            low_idx = low_idx | SW'(b);
         end
      end
      page_off   = (wbase_ff + BIT_W'(low_idx)) - start_ff;
      next_wbase = wbase_ff + BIT_W'(bpa_pkg::WORD_BITS);
      frame_diff = frame_ff - base_ff[zone_ff];
      zone_hit   = (frame_ff >= base_ff[zone_ff]) && (frame_diff < FW'(zone_pages));
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      zone_in      = zone_ff;
      clr_in       = clr_ff;
      wbase_in     = wbase_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      bitidx_in    = bitidx_ff;
      frame_in     = frame_ff;
      res_frame_in = res_frame_ff;
      res_ok_in    = res_ok_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_ok_in    = rsp_ok_ff;
      rd_addr      = wbase_ff[WORD_AW+SW-1:SW];
      mem_we       = 1'b0;
      mem_wa       = wbase_ff[WORD_AW+SW-1:SW];
      mem_wd       = rdata_ff;

      // Drop the result once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            if (clr_ff == WORD_AW'(MAP_WORDS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + WORD_AW'(1);
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               frame_in     = req_tdata[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT];
               zone_in      = '0;
               res_frame_in = '0;
               res_ok_in    = 1'b0;
               state_in     = (req_tuser == bpa_pkg::KIND_FREE) ? ST_FZONE : ST_AZONE;
            end
         end
         ST_AZONE: begin
            // Set up the scan of one zone, or skip an empty one
            if (zone_pages == '0) begin
               if (on_top_zone) begin
                  state_in = ST_DONE;
               end else begin
                  zone_in = zone_ff + 2'd1;
               end
            end else begin
               start_in = zone_start;
               end_in   = zone_start + zone_pages;
               wbase_in = {zone_start[BIT_W-1:SW], SW'(0)};
               rd_addr  = zone_start[WORD_AW+SW-1:SW];
               state_in = ST_AEVAL;
            end
         end
         ST_AEVAL: begin
            if (free_bits != '0) begin
               // Mark the page used and hold its frame for the result
               mem_we       = 1'b1;
               mem_wd       = rdata_ff | low_bit;
               res_frame_in = base_ff[zone_ff] + FW'(page_off);
               res_ok_in    = 1'b1;
               state_in     = ST_DONE;
            end else if (rem <= BIT_W'(bpa_pkg::WORD_BITS)) begin
               if (on_top_zone) begin
                  state_in = ST_DONE;
               end else begin
                  zone_in  = zone_ff + 2'd1;
                  state_in = ST_AZONE;
               end
            end else begin
               wbase_in = next_wbase;
               rd_addr  = next_wbase[WORD_AW+SW-1:SW];
            end
         end
         ST_FZONE: begin
            if (zone_hit) begin
               bitidx_in = zone_start + frame_diff[BIT_W-1:0];
               rd_addr   = bitidx_in[WORD_AW+SW-1:SW];
               res_ok_in = 1'b1;
               state_in  = ST_FWRITE;
            end else if (on_top_zone) begin
               state_in = ST_DONE;
            end else begin
               zone_in = zone_ff + 2'd1;
            end
         end
         ST_FWRITE: begin
            mem_we   = 1'b1;
            mem_wa   = bitidx_ff[WORD_AW+SW-1:SW];
            mem_wd   = rdata_ff & ~(64'd1 << bitidx_ff[SW-1:0]);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_frame_ff, bpa_pkg::PAGE_SHIFT'(0)};
               rsp_ok_in    = res_ok_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         zone_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         zone_ff      <= zone_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      wbase_ff     <= wbase_in;
      start_ff     <= start_in;
      end_ff       <= end_in;
      bitidx_ff    <= bitidx_in;
      frame_ff     <= frame_in;
      res_frame_ff <= res_frame_in;
      res_ok_ff    <= res_ok_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_ok_ff    <= rsp_ok_in;
   end

   // Zone registers: base frame on even indexes, page count on odd ones
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int z = 0; z < bpa_pkg::ZONE_COUNT; z++) begin
            base_ff[z]  <= '0;
            pages_ff[z] <= '0;
         end
      end else if (csr_we) begin
         if (csr_index[0] == bpa_pkg::CSR_SEL_BASE) begin
            base_ff[csr_index[2:1]] <= csr_wdata[FW-1:0];
         end else begin
            pages_ff[csr_index[2:1]] <= csr_wdata[bpa_pkg::COUNT_W-1:0];
         end
      end
   end

   // Bitmap memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_ff[mem_wa] <= mem_wd;
      end
      rdata_ff <= map_ff[rd_addr];
   end

   // Checks
   `BPA_ASSERT_IMPL(a_fail_has_zero_addr, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0)
   `BPA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `BPA_ASSERT_IMPL(a_scan_inside_zone, clock, reset, state_ff == ST_AEVAL, end_ff > wbase_ff)

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page allocator testbench
// Drives allocate and free requests through the stream ports under random
// sender bursts and receiver stalls. Results are checked against an
// in-bench model of the zones and used-page bitmap across several zone
// layouts, including disabled, saturated, overlapping and wrapping zones.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic [bpa_pkg::ADDR_W-1:0] page_address;
   logic                       success;
} page_result_type;

// Tracks the zone registers and the used-page bitmap, works out the result of
// every accepted request and holds it until the matching result comes back.
class page_map_scoreboard;
   logic [bpa_pkg::FRAME_W-1:0] base_frame [bpa_pkg::ZONE_COUNT];
   logic [bpa_pkg::COUNT_W-1:0] page_count [bpa_pkg::ZONE_COUNT];
   bit                          used_page  [bpa_pkg::ZONE_COUNT * bpa_pkg::PAGES_PER_ZONE_DEF];
   page_result_type             due_results [$];
   int                          mismatches;
   int                          n_alloc;
   int                          n_alloc_full;
   int                          n_free;
   int                          n_free_miss;
   int                          n_checked;

   function new();
      foreach (base_frame[z]) begin
         base_frame[z] = '0;
         page_count[z] = '0;
      end
      foreach (used_page[i]) used_page[i] = 1'b0;
      mismatches   = 0;
      n_alloc      = 0;
      n_alloc_full = 0;
      n_free       = 0;
      n_free_miss  = 0;
      n_checked    = 0;
   endfunction

   function void write_register(logic [bpa_pkg::CSR_INDEX_W-1:0] index,
                                logic [bpa_pkg::CSR_DATA_W-1:0] value);
      int z;
      z = int'(index[bpa_pkg::CSR_INDEX_W-1:1]);
      if (index[0] == bpa_pkg::CSR_SEL_BASE) begin
         base_frame[z] = value[bpa_pkg::FRAME_W-1:0];
      end else begin
         page_count[z] = value[bpa_pkg::COUNT_W-1:0];
      end
   endfunction

   // Counts above the zone size saturate
   function int unsigned usable_pages(int z);
      if (page_count[z] > bpa_pkg::PAGES_PER_ZONE_DEF) return bpa_pkg::PAGES_PER_ZONE_DEF;
      return page_count[z];
   endfunction

   function page_result_type note_request(logic kind, logic [bpa_pkg::ADDR_W-1:0] address);
      page_result_type             res;
      logic [63:0]                 frame_wide;
      logic [bpa_pkg::FRAME_W-1:0] frame;
      int unsigned                 limit;
      bit                          done;
      res  = '0;
      done = 1'b0;
      if (kind == bpa_pkg::KIND_ALLOC) begin
         n_alloc++;
         // first fit: lowest free page of the first zone with one
         for (int z = 0; z < bpa_pkg::ZONE_COUNT && !done; z++) begin
            limit = usable_pages(z);
            for (int i = 0; i < int'(limit) && !done; i++) begin
               if (!used_page[z * bpa_pkg::PAGES_PER_ZONE_DEF + i]) begin
                  used_page[z * bpa_pkg::PAGES_PER_ZONE_DEF + i] = 1'b1;
                  frame_wide       = (64'(base_frame[z]) + 64'(i)) << bpa_pkg::PAGE_SHIFT;
                  res.page_address = frame_wide[bpa_pkg::ADDR_W-1:0];
                  res.success      = 1'b1;
                  done             = 1'b1;
               end
            end
         end
         if (!done) n_alloc_full++;
      end else begin
         n_free++;
         frame = address[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT];
         // first zone holding the frame wins; the zone end is exclusive
         for (int z = 0; z < bpa_pkg::ZONE_COUNT && !done; z++) begin
            limit = usable_pages(z);
            if (frame >= base_frame[z] && 32'(frame - base_frame[z]) < limit) begin
               used_page[z * bpa_pkg::PAGES_PER_ZONE_DEF + int'(frame - base_frame[z])] = 1'b0;
               res.success = 1'b1;
               done        = 1'b1;
            end
         end
         if (!done) n_free_miss++;
      end
      due_results.push_back(res);
      return res;
   endfunction

   function void check_result(logic [bpa_pkg::ADDR_W-1:0] page_address, logic success);
      page_result_type want;
      if (due_results.size() == 0) begin
         mismatches++;
         $display("%0t: result with none outstanding: page_address %h success %b",
                  $time, page_address, success);
         return;
      end
      want = due_results.pop_front();
      n_checked++;
      if (page_address !== want.page_address) begin
         mismatches++;
         $display("%0t: page_address expected %h actual %h",
                  $time, want.page_address, page_address);
      end
      if (success !== want.success) begin
         mismatches++;
         $display("%0t: success expected %b actual %b", $time, want.success, success);
      end
   endfunction

   function int pending();
      return due_results.size();
   endfunction
endclass

module tb;

   // Ceiling on the whole run
   localparam int CYCLE_LIMIT  = 1_000_000;
   // Quiet time before reconfiguring and at the end: a full allocate scan plus margin
   localparam int DRAIN_CYCLES = 80;
   localparam int PHASE_ITEMS  = 265;

   typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_LONG} rx_pattern_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [bpa_pkg::ADDR_W-1:0]      req_tdata  = '0;
   logic                            req_tuser  = bpa_pkg::KIND_ALLOC;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [bpa_pkg::ADDR_W-1:0]      rsp_tdata;
   logic                            rsp_tuser;
   logic                            csr_we     = 1'b0;
   logic [bpa_pkg::CSR_INDEX_W-1:0] csr_index  = '0;
   logic [bpa_pkg::CSR_DATA_W-1:0]  csr_wdata  = '0;

   page_map_scoreboard              sb;
   int unsigned                     cycle_count = 0;

   // Sender pacing and the pages handed out so far, reused as free targets
   int                              burst_left = 0;
   logic [bpa_pkg::ADDR_W-1:0]      live_pages [$];

   // Zone layout for the next configuration phase
   logic [bpa_pkg::CSR_DATA_W-1:0]  zone_base_cfg  [bpa_pkg::ZONE_COUNT];
   logic [bpa_pkg::CSR_DATA_W-1:0]  zone_count_cfg [bpa_pkg::ZONE_COUNT];

   // Receiver stall pattern state
   rx_pattern_type                  rx_pattern = RX_ALWAYS;
   int unsigned                     rx_left    = 0;
   int unsigned                     rx_step    = 0;

   bitmap_page_allocator_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [47:0] address
      .req_tuser  (req_tuser),   // [0] kind
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [47:0] page_address
      .rsp_tuser  (rsp_tuser),   // [0] success
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Watchdog: give up if the run hangs
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("simulation failed");
      $finish;
   end

   // Receiver: check each result transaction, then pick the next ready level.
   // The pattern is redrawn at random between always ready, a coin toss,
   // sparse ready pulses, and long stalls.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata, rsp_tuser);
      end
      if (rx_left == 0) begin
         rx_pattern = rx_pattern_type'($urandom_range(0, 3));
         rx_left    = $urandom_range(100, 400);
         rx_step    = 0;
      end else begin
         rx_left--;
      end
      rx_step++;
      case (rx_pattern)
         RX_ALWAYS: rsp_tready <= 1'b1;
         RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_tready <= (rx_step % 8 == 0);
         default:   rsp_tready <= (rx_step % 24 >= 20);
      endcase
   end

   // Write one register; the model follows at the edge that takes the write
   task automatic csr_write(input logic [bpa_pkg::CSR_INDEX_W-1:0] index,
                            input logic [bpa_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_register(index, value);
   endtask

   // Load all eight zone registers back to back, then drop the enable
   task automatic load_zones();
      logic [1:0] zsel;
      for (int z = 0; z < bpa_pkg::ZONE_COUNT; z++) begin
         zsel = 2'(z);
         csr_write({zsel, bpa_pkg::CSR_SEL_BASE}, zone_base_cfg[z]);
         csr_write({zsel, bpa_pkg::CSR_SEL_PAGES}, zone_count_cfg[z]);
      end
      csr_we <= 1'b0;
   endtask

   // Close a burst now and then with a random gap; some bursts run long so
   // that stretches with no idling occur as well
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 20);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 10);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // Present one request and hold it until the block takes the transaction
   task automatic send_request(input logic kind, input logic [bpa_pkg::ADDR_W-1:0] address);
      page_result_type want;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= address;
      do @(posedge clock); while (!req_tready);
      want = sb.note_request(kind, address);
      if (kind == bpa_pkg::KIND_ALLOC && want.success) live_pages.push_back(want.page_address);
      pace_sender();
   endtask

   // Drain: drop valid, wait out every outstanding result and the tail of
   // any scan still running
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Half the time free pages handed out earlier, else hit zone edges, re-free pages
   // that are likely free already, or throw in a wholly random address
   function automatic logic [bpa_pkg::ADDR_W-1:0] pick_free_address();
      int                             pick;
      int                             idx;
      int                             z;
      int unsigned                    n;
      logic [bpa_pkg::FRAME_W-1:0]    frame;
      logic [bpa_pkg::PAGE_SHIFT-1:0] offset;
      logic [63:0]                    r;
      offset = bpa_pkg::PAGE_SHIFT'($urandom());
      r      = {$urandom(), $urandom()};
      pick   = $urandom_range(0, 99);
      z      = $urandom_range(0, bpa_pkg::ZONE_COUNT - 1);
      n      = sb.usable_pages(z);
      if (pick < 50 && live_pages.size() > 0) begin
         idx   = $urandom_range(0, live_pages.size() - 1);
         frame = live_pages[idx][bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT];
         live_pages.delete(idx);
      end else if (pick < 70) begin
         case ($urandom_range(0, 3))
            0:       frame = sb.base_frame[z] - 1'b1;
            1:       frame = sb.base_frame[z];
            2:       frame = sb.base_frame[z] + bpa_pkg::FRAME_W'(n) - 1'b1;
            default: frame = sb.base_frame[z] + bpa_pkg::FRAME_W'(n);
         endcase
      end else if (pick < 85) begin
         frame = sb.base_frame[z]
               + bpa_pkg::FRAME_W'($urandom_range(0, (n == 0) ? 0 : n - 1));
      end else begin
         return r[bpa_pkg::ADDR_W-1:0];
      end
      return {frame, offset};
   endfunction

   task automatic run_random(input int items, input int alloc_pct);
      logic [63:0] r;
      for (int k = 0; k < items; k++) begin
         r = {$urandom(), $urandom()};
         if ($urandom_range(0, 99) < alloc_pct) begin
            send_request(bpa_pkg::KIND_ALLOC, r[bpa_pkg::ADDR_W-1:0]);
         end else begin
            send_request(bpa_pkg::KIND_FREE, pick_free_address());
         end
      end
   endtask

   // Zone layouts for the random phases
   task automatic plan_phase(input int phase);
      int unsigned top;
      top = $urandom_range(0, 32'h7FF_FF00);
      for (int z = 0; z < bpa_pkg::ZONE_COUNT; z++) begin
         case (phase)
            1, 6: begin
               // tiny zones near frame 0: exhaustion and overlap are common
               zone_base_cfg[z]  = bpa_pkg::CSR_DATA_W'($urandom_range(0, 48));
               zone_count_cfg[z] = bpa_pkg::CSR_DATA_W'($urandom_range(0, (phase == 1) ? 4 : 2));
            end
            2: begin
               // full zones: frame 0, the top frame with wrap, a saturated
               // count, and one zone switched off
               zone_base_cfg[z]  = (z == 0) ? '0 : (z == 1) ? '1
                                 : bpa_pkg::CSR_DATA_W'($urandom());
               zone_count_cfg[z] = (z == 2) ? '1 : (z == 3) ? '0
                                 : bpa_pkg::CSR_DATA_W'(1024);
            end
            3: begin
               zone_base_cfg[z]  = bpa_pkg::CSR_DATA_W'(top + $urandom_range(0, 16));
               zone_count_cfg[z] = bpa_pkg::CSR_DATA_W'($urandom_range(1, 48));
            end
            4: begin
               // raw 27-bit counts: the upper bits must be masked off
               zone_base_cfg[z]  = bpa_pkg::CSR_DATA_W'($urandom());
               zone_count_cfg[z] = bpa_pkg::CSR_DATA_W'($urandom());
            end
            default: begin
               zone_base_cfg[z]  = bpa_pkg::CSR_DATA_W'(32'h7FF_FFFF - $urandom_range(0, 2048));
               case ($urandom_range(0, 3))
                  0:       zone_count_cfg[z] = bpa_pkg::CSR_DATA_W'(1);
                  1:       zone_count_cfg[z] = bpa_pkg::CSR_DATA_W'(1023);
                  2:       zone_count_cfg[z] = bpa_pkg::CSR_DATA_W'(1024);
                  default: zone_count_cfg[z] = bpa_pkg::CSR_DATA_W'(1025);
               endcase
            end
         endcase
      end
   endtask

   // Directed opening. Zone 0 sits at frame 0 with three pages, zone 1 at the
   // top frame so its second page wraps to address 0, zone 2 is switched off
   // and zone 3 overlaps zone 0 with a count that saturates.
   task automatic run_directed();
      zone_base_cfg[0]  = '0;
      zone_count_cfg[0] = bpa_pkg::CSR_DATA_W'(3);
      zone_base_cfg[1]  = '1;
      zone_count_cfg[1] = bpa_pkg::CSR_DATA_W'(2);
      zone_base_cfg[2]  = bpa_pkg::CSR_DATA_W'(2);
      zone_count_cfg[2] = '0;
      zone_base_cfg[3]  = bpa_pkg::CSR_DATA_W'(1);
      zone_count_cfg[3] = '1;
      load_zones();
      // fill zones 0 and 1, spill into zone 3; the address is don't-care
      send_request(bpa_pkg::KIND_ALLOC, '0);
      send_request(bpa_pkg::KIND_ALLOC, '1);
      send_request(bpa_pkg::KIND_ALLOC, 48'h5555_5555_5555);
      send_request(bpa_pkg::KIND_ALLOC, 48'hAAAA_AAAA_AAAA);
      send_request(bpa_pkg::KIND_ALLOC, '0);
      send_request(bpa_pkg::KIND_ALLOC, '0);
      // overlap: frame 1 belongs to zone 0 first; last byte of the page
      send_request(bpa_pkg::KIND_FREE, {27'd1, 21'h1F_FFFF});
      // already free
      send_request(bpa_pkg::KIND_FREE, {27'd1, 21'h0});
      send_request(bpa_pkg::KIND_ALLOC, '0);
      // just past the end of zone 0, lands in zone 3
      send_request(bpa_pkg::KIND_FREE, {27'd3, 21'h1_2345});
      // top of the address space, zone 1 page 0
      send_request(bpa_pkg::KIND_FREE, '1);
      // just past the end of saturated zone 3: no zone
      send_request(bpa_pkg::KIND_FREE, {27'd1025, 21'h0});
      send_request(bpa_pkg::KIND_FREE, {27'd1024, 21'h0});
      send_request(bpa_pkg::KIND_FREE, {27'd2, 21'h0});
      send_request(bpa_pkg::KIND_ALLOC, '0);
      settle();
      // shrink zone 0 to its used first page (bit 11 of the count is masked)
      // and switch the rest off: the bitmap keeps its contents
      zone_count_cfg[0] = bpa_pkg::CSR_DATA_W'(12'h801);
      zone_count_cfg[1] = '0;
      zone_count_cfg[3] = '0;
      load_zones();
      send_request(bpa_pkg::KIND_ALLOC, '0);
      send_request(bpa_pkg::KIND_FREE, {27'd0, 21'h0A_BCDE});
      send_request(bpa_pkg::KIND_ALLOC, '0);
      send_request(bpa_pkg::KIND_ALLOC, '0);
   endtask

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Zone registers may be loaded while the bitmap sweep runs; requests
      // simply wait for ready
      run_directed();
      for (int phase = 1; phase <= 6; phase++) begin
         settle();
         plan_phase(phase);
         load_zones();
         run_random(PHASE_ITEMS, (phase == 2) ? 65 : 55);
      end
      settle();

      $display("covered %0d allocations (%0d with every zone full), %0d frees (%0d in no zone)",
               sb.n_alloc, sb.n_alloc_full, sb.n_free, sb.n_free_miss);
      $display("%0d results compared over eight zone layouts, %0d mismatches",
               sb.n_checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+sv
sv/bpa_pkg.sv
sv/bitmap_page_allocator_top.sv
dv/tb.sv
